// ===== sv/bpa_pkg.sv =====
// Shared types and codes for the buddy page allocator.
package bpa_pkg;
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;
  localparam logic [1:0] OP_MERGE   = 2'd3;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK  = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;
  typedef struct packed {
    logic [1:0]  op;
    logic [12:0] size_kb;
    logic [9:0]  page_index;
    logic [9:0]  last_page;
  } bpa_req_t;
  typedef struct packed {
    logic [1:0] status;
    logic [9:0] block_page;
    logic [3:0] block_order;
  } bpa_rsp_t;
endpackage

// ===== sv/bpa_if.sv =====
// Valid/ready channel carrying one payload.
interface bpa_req_if import bpa_pkg::*; ();
  logic     valid;
  logic     ready;
  bpa_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic     valid;
  logic     ready;
  bpa_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/buddy_page_allocator.sv =====
// Buddy page allocator: per-page state, orders and free lists held in memories.
// One transaction at a time. Each memory read is registered. An alloc scans the free lists
// upward from the wanted order, splits larger blocks down and then takes the block. A free
// returns the block and then runs a merge pass. A merge check or pass merges buddies level
// by level until it finds that nothing more merges. A reserve unlinks and marks each page
// in turn. After reset a clearing pass builds the order-0 list before input is taken.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int PAGE_COUNT = 1024,
  parameter int MAX_ORDER  = 10
) (
  input logic clk,
  input logic rst_n,
  bpa_req_if.sink   in_req,
  bpa_rsp_if.source out_rsp
);
  localparam int NODES = PAGE_COUNT + MAX_ORDER + 1;
  localparam int NW = $clog2(NODES + 1);
  localparam int PW = $clog2(PAGE_COUNT);
  localparam int OW = $clog2(MAX_ORDER + 3);
  localparam logic [OW-1:0] S_LEFT  = OW'(MAX_ORDER + 1);
  localparam logic [OW-1:0] S_ALLOC = OW'(MAX_ORDER + 2);
  localparam logic [NW-1:0] HEAD0 = NW'(PAGE_COUNT);
  localparam logic [NW-1:0] NLAST = NW'(NODES - 1);

  localparam logic [4:0] F_INIT=5'd0, F_IDLE=5'd1, F_SCAN=5'd2, F_SCANW=5'd3,
    F_RD=5'd4, F_RDW=5'd5, F_UNL=5'd6, F_PUSH=5'd7, F_PUSHW=5'd8, F_PUSH2=5'd9,
    F_FREE=5'd10, F_FREEW=5'd11, F_MG=5'd12, F_MGW=5'd13, F_MG2=5'd14,
    F_MG2W=5'd15, F_OUT=5'd16, F_RES=5'd17, F_RESW=5'd18, F_DISP=5'd19,
    F_MGE=5'd28, F_MGO=5'd29, F_MGL=5'd30, F_MGU=5'd31;

  localparam logic [2:0] A_SPLIT=3'd0, A_TAKE=3'd1, A_MERGE=3'd2, A_RES=3'd3,
    A_FREE=3'd4;

  logic [OW-1:0] st_mem [PAGE_COUNT];
  logic [OW-1:0] ord_mem [PAGE_COUNT];
  logic [NW-1:0] nx_mem [NODES];
  logic [NW-1:0] pv_mem [NODES];

  logic [4:0] fsm_r, ret_r;
  logic [2:0] act_r;
  logic [NW-1:0] cnt_r;
  bpa_rsp_t rsp_r;
  logic [OW-1:0] lvl_r, k_r;
  logic [NW-1:0] n_r, p_r, x_r, t_r, b_r;
  logic [PW-1:0] last_r;
  logic [2:0] sub_r;

  // memory ports: one read address and one write per memory
  logic [NW-1:0] ra_r, nwa, pwa, nwd, pwd;
  logic nwe, pwe;
  logic [PW-1:0] sra, swa;
  logic [OW-1:0] swd, owd;
  logic swe, owe;
  logic [NW-1:0] nrd_r, prd_r;
  logic [OW-1:0] srd_r, ord_r;

  always_ff @(posedge clk) begin
    if (nwe) nx_mem[nwa] <= nwd;
    if (pwe) pv_mem[pwa] <= pwd;
    if (swe) st_mem[swa] <= swd;
    if (owe) ord_mem[swa] <= owd;
    nrd_r <= nx_mem[ra_r[NW-1:0] < NW'(NODES) ? ra_r : '0];
    prd_r <= pv_mem[ra_r < NW'(NODES) ? ra_r : '0];
    srd_r <= st_mem[sra];
    ord_r <= ord_mem[sra];
  end

  assign in_req.ready = (fsm_r == F_IDLE) && !out_rsp.valid;
  logic ovalid_r;
  assign out_rsp.valid = ovalid_r;
  assign out_rsp.data = rsp_r;

  // size rounding
  logic [4:0] want;
  always_comb begin
    want = '0;
    for (int j = 0; j < 12; j++)
      if ((14'(4) << j) < {1'b0, in_req.data.size_kb}) want = 5'(j + 1);
  end

  // pointer ops: sub-steps of unlink(n_r) and push(n_r, k_r)
  logic [NW-1:0] headk;
  assign headk = HEAD0 + NW'(k_r);

  always_comb begin
    nwe = 1'b0; pwe = 1'b0; nwa = '0; pwa = '0; nwd = '0; pwd = '0;
    swe = 1'b0; owe = 1'b0; swa = '0; swd = '0; owd = '0;
    sra = n_r[PW-1:0];
    if (fsm_r == F_INIT) begin
      nwe = 1'b1; pwe = 1'b1; nwa = cnt_r; pwa = cnt_r;
      nwd = (cnt_r == HEAD0 - 1) ? HEAD0 : (cnt_r >= HEAD0 ? cnt_r : cnt_r + 1'b1);
      pwd = (cnt_r == '0) ? HEAD0 : (cnt_r == HEAD0 ? HEAD0 - 1 :
            (cnt_r > HEAD0 ? cnt_r : cnt_r - 1'b1));
      if (cnt_r == HEAD0) nwd = (PAGE_COUNT > 0) ? '0 : HEAD0;
      if (cnt_r < HEAD0) begin
        swe = 1'b1; owe = 1'b1; swa = cnt_r[PW-1:0];
      end
    end else if (fsm_r == F_UNL) begin
      nwe = 1'b1; nwa = p_r; nwd = x_r;
      pwe = 1'b1; pwa = x_r; pwd = p_r;
    end else if (fsm_r == F_PUSH) begin
      nwe = 1'b1; nwa = n_r; nwd = n_r;
      pwe = 1'b1; pwa = n_r; pwd = n_r;
    end else if (fsm_r == F_PUSH2) begin
      nwe = 1'b1; nwa = n_r; nwd = nrd_r;
      pwe = 1'b1; pwa = n_r; pwd = headk;
    end else if (fsm_r == F_OUT) begin
      nwe = 1'b1; nwa = headk; nwd = n_r;
      pwe = 1'b1; pwa = x_r; pwd = n_r;
    end
    if (fsm_r == F_MGL) begin
      swe = 1'b1; swa = n_r[PW-1:0]; swd = S_LEFT;
    end else if (fsm_r == F_MGO) begin
      swe = 1'b1; owe = 1'b1; swa = n_r[PW-1:0]; swd = k_r; owd = k_r;
    end
    if (fsm_r == F_DISP) begin
      swa = n_r[PW-1:0];
      case (act_r)
        A_SPLIT: begin swe = 1'b1; owe = 1'b1; swd = k_r; owd = k_r; end
        A_TAKE:  begin swe = 1'b1; owe = 1'b1; swd = S_ALLOC; owd = lvl_r; end
        A_MERGE: begin
          swe = 1'b1;
          if (sub_r[0]) swd = S_LEFT;
          else begin owe = 1'b1; swd = k_r; owd = k_r; end
        end
        A_RES:   begin swe = 1'b1; swd = S_ALLOC; end
        A_FREE:  begin swe = 1'b1; swd = k_r; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= F_INIT; cnt_r <= '0; ovalid_r <= 1'b0; ra_r <= '0; sub_r <= '0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) ovalid_r <= 1'b0;
      case (fsm_r)
        F_INIT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == NLAST) fsm_r <= F_IDLE;
        end
        F_IDLE: if (in_req.valid && in_req.ready) begin
          case (in_req.data.op)
            OP_ALLOC: begin
              if (want > 5'(MAX_ORDER)) begin
                rsp_r <= {ST_TOO_LARGE, 10'd0, 4'd0}; ovalid_r <= 1'b1;
              end else begin
                rsp_r <= '0;
                lvl_r <= OW'(want); k_r <= OW'(want);
                ra_r <= HEAD0 + NW'(want); fsm_r <= F_SCANW;
              end
            end
            OP_FREE: begin
              if (32'(in_req.data.page_index) >= PAGE_COUNT) begin
                rsp_r <= {ST_NOT_ALLOC, 10'd0, 4'd0}; ovalid_r <= 1'b1;
              end else begin
                rsp_r <= '0;
                n_r <= NW'(in_req.data.page_index); fsm_r <= F_FREEW;
              end
            end
            OP_RESERVE: begin
              rsp_r <= '0;
              last_r <= (32'(in_req.data.last_page) >= PAGE_COUNT) ? PW'(PAGE_COUNT - 1)
                        : PW'(in_req.data.last_page);
              n_r <= NW'(in_req.data.page_index);
              if (32'(in_req.data.page_index) >= PAGE_COUNT ||
                  (32'(in_req.data.last_page) < PAGE_COUNT &&
                   in_req.data.page_index > in_req.data.last_page))
                ovalid_r <= 1'b1;
              else fsm_r <= F_RES;
            end
            default: begin
              rsp_r <= '0;
              if (32'(in_req.data.page_index) >= PAGE_COUNT) ovalid_r <= 1'b1;
              else begin n_r <= NW'(in_req.data.page_index); fsm_r <= F_MGW; end
            end
          endcase
        end
        F_SCANW: fsm_r <= F_SCAN;
        F_SCAN: begin
          if (nrd_r != headk) begin
            n_r <= nrd_r; ra_r <= nrd_r;
            act_r <= (k_r == lvl_r) ? A_TAKE : A_SPLIT;
            ret_r <= F_DISP; fsm_r <= F_RDW;
          end else if (k_r == OW'(MAX_ORDER)) begin
            rsp_r.status <= ST_NO_BLOCK; ovalid_r <= 1'b1; fsm_r <= F_IDLE;
          end else begin
            k_r <= k_r + 1'b1; ra_r <= headk + 1'b1; fsm_r <= F_SCANW;
          end
        end
        // unlink n_r: read its links, then patch neighbours and self
        F_RDW: fsm_r <= F_RD;
        F_RD: begin p_r <= prd_r; x_r <= nrd_r; fsm_r <= F_UNL; end
        F_UNL: fsm_r <= F_PUSH;
        F_PUSH: begin
          fsm_r <= ret_r;
        end
        // push n_r at head of k_r: read head next
        F_PUSHW: fsm_r <= F_PUSH2;
        F_PUSH2: begin x_r <= nrd_r; fsm_r <= F_OUT; end
        F_OUT: fsm_r <= ret_r;
        F_DISP: begin
          // state writes happen combinationally in this cycle
          case (act_r)
            A_SPLIT: begin
              if (sub_r == 3'd0) begin
                k_r <= k_r - 1'b1;
                b_r <= n_r + (NW'(1) << (k_r - 1'b1));
                t_r <= n_r; sub_r <= 3'd1;
                if (32'(n_r + (NW'(1) << (k_r - 1'b1))) < PAGE_COUNT) begin
                  n_r <= n_r + (NW'(1) << (k_r - 1'b1));
                  ret_r <= F_DISP; ra_r <= HEAD0 + NW'(k_r - 1'b1); fsm_r <= F_PUSHW;
                end else begin
                  sub_r <= 3'd2; ra_r <= HEAD0 + NW'(k_r - 1'b1); fsm_r <= F_PUSHW;
                end
              end else if (sub_r == 3'd1) begin
                n_r <= t_r; sub_r <= 3'd2; ra_r <= headk; fsm_r <= F_PUSHW;
              end else begin
                sub_r <= 3'd0;
                if (k_r == lvl_r) act_r <= A_TAKE;
                ra_r <= headk; fsm_r <= F_SCANW;
              end
            end
            A_TAKE: begin
              rsp_r.block_page <= 10'(n_r); rsp_r.block_order <= 4'(lvl_r);
              ovalid_r <= 1'b1; fsm_r <= F_IDLE;
            end
            A_MERGE: begin
              if (sub_r == 3'd0) begin
                sub_r <= 3'd1; n_r <= t_r; ra_r <= t_r; fsm_r <= F_RDW;
              end else if (sub_r == 3'd1) begin
                sub_r <= 3'd2; n_r <= b_r; ra_r <= headk; fsm_r <= F_PUSHW;
              end else begin
                sub_r <= 3'd0; fsm_r <= F_MGW;
              end
            end
            A_RES: begin
              if (n_r[PW-1:0] == last_r) begin ovalid_r <= 1'b1; fsm_r <= F_IDLE; end
              else begin n_r <= n_r + 1'b1; fsm_r <= F_RES; end
            end
            default: begin
              act_r <= A_MERGE; sub_r <= 3'd2; b_r <= n_r;
              rsp_r.block_page <= 10'(n_r); rsp_r.block_order <= 4'(k_r);
              ra_r <= headk; fsm_r <= F_PUSHW;
            end
          endcase
        end
        F_FREEW: fsm_r <= F_FREE;
        F_FREE: begin
          if (srd_r != S_ALLOC) begin
            rsp_r.status <= ST_NOT_ALLOC; ovalid_r <= 1'b1; fsm_r <= F_IDLE;
          end else begin
            k_r <= (ord_r > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : ord_r;
            act_r <= A_FREE; ret_r <= F_DISP; fsm_r <= F_DISP;
          end
        end
        // merge pass: read state of n_r, then of buddy
        F_MGW: fsm_r <= F_MG;
        F_MG: begin
          k_r <= srd_r;
          if (srd_r >= OW'(MAX_ORDER)) begin
            ovalid_r <= 1'b1; fsm_r <= F_IDLE;
          end else begin
            t_r <= n_r; n_r <= n_r ^ (NW'(1) << srd_r); fsm_r <= F_MG2W;
          end
        end
        F_MG2W: fsm_r <= F_MG2;
        F_MG2: begin
          if (32'(n_r) >= PAGE_COUNT || srd_r != k_r) begin
            ovalid_r <= 1'b1; fsm_r <= F_IDLE;
          end else begin
            // unlink lo first, then hi; b_r carries lo
            b_r <= (t_r < n_r) ? t_r : n_r;
            t_r <= (t_r < n_r) ? n_r : t_r;
            n_r <= (t_r < n_r) ? t_r : n_r;
            ra_r <= (t_r < n_r) ? t_r : n_r;
            act_r <= A_MERGE; sub_r <= 3'd0; ret_r <= F_MGU;
            fsm_r <= F_RDW;
          end
        end
        F_MGU: begin
          // after unlink of lo: unlink hi, then write states and push lo
          if (sub_r == 3'd0) begin
            sub_r <= 3'd1; n_r <= t_r; ra_r <= t_r; fsm_r <= F_RDW;
          end else begin
            // hi: LEFT state, then lo: order k+1
            k_r <= k_r + 1'b1; sub_r <= 3'd3; fsm_r <= F_MGL;
          end
        end
        F_MGL: begin
          // write hi state
          n_r <= b_r; sub_r <= 3'd4; fsm_r <= F_MGO;
        end
        F_MGO: begin
          act_r <= A_MERGE; sub_r <= 3'd2; ra_r <= headk; fsm_r <= F_PUSHW;
          ret_r <= F_MGE;
        end
        F_MGE: begin
          sub_r <= 3'd0; fsm_r <= F_MGW;
        end
        F_RES: begin
          ra_r <= n_r; act_r <= A_RES; ret_r <= F_DISP; fsm_r <= F_RDW;
        end
        default: fsm_r <= F_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/bpa_checker.sv =====
// Port-level checks for the buddy page allocator, bound to the allocator module.
module bpa_checker import bpa_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status
);
  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status)) else $error("status changed");
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .out_status(out_rsp.data.status));

// ===== tb/tb_top.sv =====
// Self-checking testbench for the buddy page allocator, with its own predictor.
module tb_top;
  import bpa_pkg::*;

  localparam int PAGES   = 1024;
  localparam int TOP_ORD = 10;
  localparam int PG_LEFT  = TOP_ORD + 1;
  localparam int PG_ALLOC = TOP_ORD + 2;
  localparam int NODES   = PAGES + TOP_ORD + 1;
  localparam int WDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;

  bpa_req_if req_if ();
  bpa_rsp_if rsp_if ();

  buddy_page_allocator u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if.sink),
    .out_rsp (rsp_if.source)
  );

  int pg_state [PAGES];
  int pg_order [PAGES];
  int nxt [NODES];
  int prv [NODES];

  bpa_rsp_t expected_rsp[$];
  int  errors;
  int  idle_cycles;
  int  hold_left;
  int  stall_left;
  bit  idle_en;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void list_unlink(int n);
    int p;
    int x;
    p = prv[n];
    x = nxt[n];
    nxt[p] = x;
    prv[x] = p;
    nxt[n] = n;
    prv[n] = n;
  endfunction

  function automatic void list_push(int n, int ord);
    int h;
    int x;
    h = PAGES + ord;
    x = nxt[h];
    nxt[n] = x;
    prv[n] = h;
    prv[x] = n;
    nxt[h] = n;
  endfunction

  function automatic void coalesce(int i);
    int lvl;
    int bud;
    int lo;
    int hi;
    while (i < PAGES) begin
      lvl = pg_state[i];
      if (lvl >= TOP_ORD) return;
      bud = i ^ (1 << lvl);
      if (bud >= PAGES || pg_state[bud] != lvl) return;
      lo = (i < bud) ? i : bud;
      hi = (i < bud) ? bud : i;
      list_unlink(lo);
      list_unlink(hi);
      pg_state[lo] = lvl + 1;
      pg_state[hi] = PG_LEFT;
      pg_order[lo] = lvl + 1;
      list_push(lo, lvl + 1);
      i = lo;
    end
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i < NODES; i++) begin
      nxt[i] = i;
      prv[i] = i;
    end
    for (int i = 0; i < PAGES; i++) begin
      pg_state[i] = 0;
      pg_order[i] = 0;
      list_push(i, 0);
      list_unlink(i);
      nxt[prv[PAGES]] = i;
      prv[i] = prv[PAGES];
      nxt[i] = PAGES;
      prv[PAGES] = i;
    end
  endfunction

  function automatic bpa_rsp_t allocate_or_free(bpa_req_t r);
    bpa_rsp_t res;
    int lvl;
    int sz;
    int k;
    int t;
    int b;
    int pg;
    int last;
    res = '0;
    res.status = ST_OK;
    case (r.op)
      OP_ALLOC: begin
        lvl = 0;
        sz = 4;
        while (sz < int'(r.size_kb)) begin
          sz = sz << 1;
          lvl++;
        end
        if (lvl > TOP_ORD) begin
          res.status = ST_TOO_LARGE;
        end else begin
          k = lvl;
          while (k <= TOP_ORD && nxt[PAGES + k] == PAGES + k) k++;
          if (k > TOP_ORD) begin
            res.status = ST_NO_BLOCK;
          end else begin
            while (k > lvl) begin
              t = nxt[PAGES + k];
              b = t + (1 << (k - 1));
              list_unlink(t);
              pg_state[t] = k - 1;
              pg_order[t] = k - 1;
              if (b < PAGES) begin
                pg_state[b] = k - 1;
                pg_order[b] = k - 1;
                list_push(b, k - 1);
              end
              list_push(t, k - 1);
              k--;
            end
            pg = nxt[PAGES + lvl];
            list_unlink(pg);
            pg_state[pg] = PG_ALLOC;
            pg_order[pg] = lvl;
            res.block_page = pg[9:0];
            res.block_order = lvl[3:0];
          end
        end
      end
      OP_FREE: begin
        pg = r.page_index;
        if (pg >= PAGES || pg_state[pg] != PG_ALLOC) begin
          res.status = ST_NOT_ALLOC;
        end else begin
          lvl = pg_order[pg];
          if (lvl > TOP_ORD) lvl = TOP_ORD;
          pg_state[pg] = lvl;
          list_push(pg, lvl);
          coalesce(pg);
          res.block_page = pg[9:0];
          res.block_order = lvl[3:0];
        end
      end
      OP_RESERVE: begin
        last = r.last_page;
        if (last >= PAGES) last = PAGES - 1;
        for (int i = r.page_index; i <= last; i++) begin
          pg_state[i] = PG_ALLOC;
          list_unlink(i);
        end
      end
      default: begin
        if (r.page_index < PAGES) coalesce(r.page_index);
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_req(bpa_req_t r);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(negedge clk); while (!req_if.ready);
    @(posedge clk);
    expected_rsp.push_back(allocate_or_free(r));
  endtask

  task automatic idle_input();
    req_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic bpa_req_t mk_req(logic [1:0] op, int sz, int pg, int last);
    bpa_req_t r;
    r.op = op;
    r.size_kb = sz[12:0];
    r.page_index = pg[9:0];
    r.last_page = last[9:0];
    return r;
  endfunction

  function automatic int pick_allocated();
    int start;
    start = $urandom_range(0, PAGES - 1);
    for (int i = 0; i < PAGES; i++)
      if (pg_state[(start + i) % PAGES] == PG_ALLOC) return (start + i) % PAGES;
    return start;
  endfunction

  function automatic bpa_req_t random_req();
    int sel;
    int pg;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      if ($urandom_range(0, 9) == 0)
        return mk_req(OP_ALLOC, $urandom_range(0, 8191), $urandom, $urandom);
      return mk_req(OP_ALLOC, $urandom_range(0, 96), $urandom, $urandom);
    end else if (sel < 75) begin
      return mk_req(OP_FREE, $urandom, pick_allocated(), $urandom);
    end else if (sel < 82) begin
      return mk_req(OP_FREE, $urandom, $urandom_range(0, PAGES - 1), $urandom);
    end else if (sel < 90) begin
      pg = $urandom_range(0, PAGES - 1);
      if ($urandom_range(0, 5) == 0)
        return mk_req(OP_RESERVE, $urandom, pg, $urandom_range(0, PAGES - 1));
      return mk_req(OP_RESERVE, $urandom, pg, pg + $urandom_range(0, 7));
    end
    return mk_req(OP_MERGE, $urandom, $urandom_range(0, PAGES - 1), $urandom);
  endfunction

  task automatic test_directed();
    send_req(mk_req(OP_ALLOC, 0, 0, 0));
    send_req(mk_req(OP_ALLOC, 4, 0, 0));
    send_req(mk_req(OP_ALLOC, 5, 0, 0));
    send_req(mk_req(OP_ALLOC, 8191, 1023, 1023));
    send_req(mk_req(OP_ALLOC, 4097, 0, 0));
    send_req(mk_req(OP_FREE, 0, 0, 0));
    send_req(mk_req(OP_FREE, 0, 1, 0));
    send_req(mk_req(OP_FREE, 0, 2, 0));
    send_req(mk_req(OP_FREE, 0, 1023, 0));
    send_req(mk_req(OP_MERGE, 0, 0, 0));
    send_req(mk_req(OP_MERGE, 0, 2, 0));
    send_req(mk_req(OP_MERGE, 0, 1023, 0));
    send_req(mk_req(OP_RESERVE, 0, 10, 5));
    send_req(mk_req(OP_RESERVE, 0, 1000, 1023));
    send_req(mk_req(OP_ALLOC, 4096, 0, 0));
    send_req(mk_req(OP_FREE, 0, 1000, 0));
    send_req(mk_req(OP_RESERVE, 0, 16, 47));
    send_req(mk_req(OP_FREE, 0, 32, 0));
    send_req(mk_req(OP_MERGE, 0, 32, 0));
    send_req(mk_req(OP_ALLOC, 2048, 0, 0));
    send_req(mk_req(OP_ALLOC, 2048, 0, 0));
    send_req(mk_req(OP_ALLOC, 4, 0, 0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_req(random_req());
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_left = 400;
    @(posedge clk);
    test_random(20);
  endtask

  task automatic test_drain_pause();
    idle_input();
    wait_drained();
    test_random(20);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    bpa_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_if.data.status !== want.status)
          report_mismatch("status", rsp_if.data.status, want.status);
        if (rsp_if.data.block_page !== want.block_page)
          report_mismatch("block_page", rsp_if.data.block_page, want.block_page);
        if (rsp_if.data.block_order !== want.block_order)
          report_mismatch("block_order", rsp_if.data.block_order, want.block_order);
      end
    end
  end

  always @(negedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_left = 0;
    idle_en = 1'b1;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    pool_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_backpressure();
    test_drain_pause();
    test_random(400);
    idle_en = 1'b0;
    test_random(150);
    idle_input();
    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
